// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, word width default,
// controller-to-datapath command and status types. No dependencies.
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_NEG = 4'd4,
        OP_SIMP = 4'd5,
        OP_CMP = 4'd6,
        OP_MIN = 4'd7,
        OP_MAX = 4'd8
    } t_op;

    // datapath micro-commands
    typedef enum logic [3:0] {
        DC_NONE = 4'd0,
        DC_LOAD = 4'd1,   // capture operands, apply div pre-transform, form cross products
        DC_MULA = 4'd2,   // product a_n*b_d (or n*n)
        DC_MULB = 4'd3,   // second product
        DC_MULC = 4'd4,   // denominator product
        DC_CHK = 4'd5,    // range check, form result
        DC_GSET = 4'd6,   // start gcd on selected operand
        DC_DIVS = 4'd7,   // start division p/q
        DC_DIVI = 4'd8,   // one divider step
        DC_GSTEP = 4'd9,  // p <= q, q <= rem
        DC_QN = 4'd10,    // start n/g
        DC_QD = 4'd11,    // start d/g
        DC_APPLY = 4'd12, // write reduced fraction back
        DC_CMPR = 4'd13,  // compare result
        DC_NEGF = 4'd14,  // final negate handling
        DC_FIN = 4'd15    // result for simplify
    } t_dcmd;

    typedef struct packed {
        t_dcmd cmd;
        logic  sel_b;   // operate reduction on b
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic q_zero;    // gcd loop ends
        logic fits;      // products all in range
        logic red_ok;    // last reduce returned true
        logic g_zero;
        logic neg_min;   // numerator is most negative value
    } t_sts;

endpackage

// ===== hw/rtl/rau_if.sv =====
// Valid/ready channel interface for the rational arithmetic unit.
// Depends on nothing; payload carried as a packed vector.
interface rau_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rau_ctrl.sv =====
// Controller state machine for the rational arithmetic unit.
// Depends on rau_pkg; drives commands to rau_dp and reads its status.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_mode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic [2:0] o_tries
);

    typedef enum logic [17:0] {
        S_IDLE = 18'd1,
        S_LOAD = 18'd2,
        S_MA = 18'd4,
        S_MB = 18'd8,
        S_MC = 18'd16,
        S_CHK = 18'd32,
        S_GSET = 18'd64,
        S_GTEST = 18'd128,
        S_DIVS = 18'd256,
        S_DIVI = 18'd512,
        S_GSTEP = 18'd1024,
        S_QN = 18'd2048,
        S_QNI = 18'd4096,
        S_QD = 18'd8192,
        S_QDI = 18'd16384,
        S_APPLY = 18'd32768,
        S_POST = 18'd65536,
        S_OUT = 18'd131072
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_mode, n_mode;
    logic       r_selb, n_selb;
    logic [2:0] r_tries, n_tries;

    logic arith;
    assign arith = (r_mode == OP_ADD) || (r_mode == OP_SUB) || (r_mode == OP_MUL)
                   || (r_mode == OP_DIV);

    assign o_tries = r_tries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= '0;
            r_selb  <= 1'b0;
            r_tries <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_selb  <= n_selb;
            r_tries <= n_tries;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_selb = r_selb;
        n_tries = r_tries;
        o_ctl.cmd = DC_NONE;
        o_ctl.sel_b = r_selb;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.cmd = DC_LOAD;
                    n_mode = i_mode;
                    n_tries = '0;
                    n_selb = (i_mode == OP_SUB);
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_mode == OP_SUB || r_mode == OP_NEG) begin
                    // negate needs a reduce first when numerator is most negative
                    if (i_sts.neg_min) n_state = S_GSET;
                    else begin
                        o_ctl.cmd = DC_NEGF;
                        n_state = (r_mode == OP_SUB) ? S_MA : S_OUT;
                    end
                end else if (r_mode == OP_SIMP) begin
                    n_selb = 1'b0;
                    n_state = S_GSET;
                end else if (arith) n_state = S_MA;
                else begin
                    o_ctl.cmd = DC_CMPR;
                    n_state = S_OUT;
                end
            end
            S_MA: begin o_ctl.cmd = DC_MULA; n_state = S_MB; end
            S_MB: begin o_ctl.cmd = DC_MULB; n_state = S_MC; end
            S_MC: begin o_ctl.cmd = DC_MULC; n_state = S_CHK; end
            S_CHK: begin
                o_ctl.cmd = DC_CHK;
                if (i_sts.fits || r_tries == 3'd4) n_state = S_OUT;
                else begin
                    n_tries = r_tries + 3'd1;
                    n_selb = 1'b0;
                    n_state = S_GSET;
                end
            end
            S_GSET: begin o_ctl.cmd = DC_GSET; n_state = S_GTEST; end
            S_GTEST: begin
                if (i_sts.q_zero) n_state = S_QN;
                else n_state = S_DIVS;
            end
            S_DIVS: begin o_ctl.cmd = DC_DIVS; n_state = S_DIVI; end
            S_DIVI: begin
                o_ctl.cmd = DC_DIVI;
                if (i_sts.div_done) n_state = S_GSTEP;
            end
            S_GSTEP: begin o_ctl.cmd = DC_GSTEP; n_state = S_GTEST; end
            S_QN: begin
                if (i_sts.g_zero) n_state = S_POST;
                else begin o_ctl.cmd = DC_QN; n_state = S_QNI; end
            end
            S_QNI: begin
                o_ctl.cmd = DC_DIVI;
                if (i_sts.div_done) n_state = S_QD;
            end
            S_QD: begin o_ctl.cmd = DC_QD; n_state = S_QDI; end
            S_QDI: begin
                o_ctl.cmd = DC_DIVI;
                if (i_sts.div_done) n_state = S_APPLY;
            end
            S_APPLY: begin o_ctl.cmd = DC_APPLY; n_state = S_POST; end
            S_POST: begin
                if (r_mode == OP_SIMP) begin
                    o_ctl.cmd = DC_FIN;
                    n_state = S_OUT;
                end else if (r_mode == OP_NEG || (r_mode == OP_SUB && r_tries == 3'd0)) begin
                    o_ctl.cmd = DC_NEGF;
                    n_state = (r_mode == OP_NEG) ? S_OUT : S_MA;
                end else if (i_sts.red_ok) n_state = S_MA;
                else if (!r_selb) begin
                    n_selb = 1'b1;
                    n_state = S_GSET;
                end else begin
                    n_tries = 3'd4;
                    n_state = S_CHK;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/rau_dp.sv =====
// Datapath for the rational arithmetic unit: operand registers, WORD_BITS x WORD_BITS products,
// a shared radix-2 divider for the gcd loop and quotients.
// Depends on rau_pkg; commanded by rau_ctrl.
module rau_dp
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  t_ctl        i_ctl,
    input  logic [3:0]  i_mode,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    input  logic [2:0]  i_tries,
    output t_sts        o_sts,
    output logic [31:0] o_res_num,
    output logic [31:0] o_res_den,
    output logic [1:0]  o_order,
    output logic        o_status
);
    localparam int W = WORD_BITS;
    localparam int P = 2 * W;
    localparam int CW = $clog2(W + 1);
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd, n_an, n_ad, n_bn, n_bd;
    logic signed [W-1:0] r_rn, r_rd, n_rn, n_rd;
    logic signed [P-1:0] r_p1, r_p2, r_p3, n_p1, n_p2, n_p3;
    logic [1:0]          r_ord, n_ord;
    logic                r_ovf, n_ovf, r_redok, n_redok;
    logic [3:0]          r_mode;
    // gcd registers
    logic signed [W-1:0] r_gp, r_gq, n_gp, n_gq, r_qn, n_qn;
    // divider
    logic [W-1:0]  r_dq, n_dq, r_dr, n_dr, r_dv, n_dv;
    logic [CW-1:0] r_dc, n_dc;
    logic          r_dnq, r_dnr, n_dnq, n_dnr, r_dm1, n_dm1;

    logic signed [W-1:0] cn, cd;   // selected operand
    logic signed [P-1:0] sum;
    logic [W:0]          trial;
    logic signed [W-1:0] quo, rem;
    logic                fits, qm1;

    function automatic logic inr(input logic signed [P-1:0] v);
        return v == P'(signed'(v[W-1:0]));
    endfunction

    assign cn = i_ctl.sel_b ? r_bn : r_an;
    assign cd = i_ctl.sel_b ? r_bd : r_ad;
    assign sum = r_p1 + r_p2;
    assign trial = {r_dr, r_dq[W-1]} - {1'b0, r_dv};
    assign quo = r_dm1 ? '0 : (r_dnq ? -signed'(r_dq) : signed'(r_dq));
    assign rem = r_dm1 ? '0 : (r_dnr ? -signed'(r_dr) : signed'(r_dr));
    assign fits = inr(r_p1) && inr(r_p2) && inr(r_p3) && inr(sum);
    assign qm1 = (r_gp == -W'(1)) && ((cn == WMIN) || (cd == WMIN));

    always_ff @(posedge i_clk) begin
        r_an <= n_an; r_ad <= n_ad; r_bn <= n_bn; r_bd <= n_bd;
        r_rn <= n_rn; r_rd <= n_rd; r_p1 <= n_p1; r_p2 <= n_p2; r_p3 <= n_p3;
        r_ord <= n_ord; r_ovf <= n_ovf; r_redok <= n_redok;
        r_gp <= n_gp; r_gq <= n_gq; r_qn <= n_qn;
        r_dq <= n_dq; r_dr <= n_dr; r_dv <= n_dv; r_dc <= n_dc;
        r_dnq <= n_dnq; r_dnr <= n_dnr; r_dm1 <= n_dm1;
        if (i_ctl.cmd == DC_LOAD) r_mode <= i_mode;
    end

    always_comb begin
        logic signed [W-1:0] dvd, dvs;
        logic signed [W-1:0] fn, fd;
        n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_rn = r_rn; n_rd = r_rd; n_p1 = r_p1; n_p2 = r_p2; n_p3 = r_p3;
        n_ord = r_ord; n_ovf = r_ovf; n_redok = r_redok;
        n_gp = r_gp; n_gq = r_gq; n_qn = r_qn;
        n_dq = r_dq; n_dr = r_dr; n_dv = r_dv; n_dc = r_dc;
        n_dnq = r_dnq; n_dnr = r_dnr; n_dm1 = r_dm1;
        dvd = '0; dvs = '0;
        fn = cn; fd = cd;
        case (i_ctl.cmd)
            DC_LOAD: begin
                n_an = i_a_num[W-1:0]; n_ad = i_a_den[W-1:0];
                if (i_mode == OP_DIV) begin
                    n_bn = i_b_den[W-1:0]; n_bd = i_b_num[W-1:0];
                end else begin
                    n_bn = i_b_num[W-1:0]; n_bd = i_b_den[W-1:0];
                end
                n_rn = '0; n_rd = '0; n_ord = '0; n_ovf = 1'b0;
                n_p1 = P'(signed'(i_a_num[W-1:0])) * P'(signed'(i_b_den[W-1:0]));
                n_p2 = P'(signed'(i_a_den[W-1:0])) * P'(signed'(i_b_num[W-1:0]));
            end
            DC_CMPR: begin
                // spare codes leave the order at zero
                if (r_mode == OP_CMP || r_mode == OP_MIN || r_mode == OP_MAX) begin
                    n_ord = (r_p1 > r_p2) ? 2'b01 : ((r_p1 < r_p2) ? 2'b11 : 2'b00);
                end
                if (r_mode == OP_MIN) begin
                    n_rn = (r_p1 < r_p2) ? r_an : r_bn;
                    n_rd = (r_p1 < r_p2) ? r_ad : r_bd;
                end else if (r_mode == OP_MAX) begin
                    n_rn = (r_p1 > r_p2) ? r_an : r_bn;
                    n_rd = (r_p1 > r_p2) ? r_ad : r_bd;
                end
            end
            DC_MULA: begin
                if (r_mode == OP_MUL || r_mode == OP_DIV) n_p1 = P'(r_an) * P'(r_bn);
                else n_p1 = P'(r_an) * P'(r_bd);
            end
            DC_MULB: begin
                if (r_mode == OP_MUL || r_mode == OP_DIV) n_p2 = '0;
                else n_p2 = P'(r_bn) * P'(r_ad);
            end
            DC_MULC: n_p3 = P'(r_ad) * P'(r_bd);
            DC_CHK: begin
                if (fits) begin
                    n_rn = sum[W-1:0]; n_rd = r_p3[W-1:0];
                end else if (i_tries == 3'd4) begin
                    n_ovf = 1'b1; n_rn = '0; n_rd = '0;
                end
            end
            DC_GSET: begin
                n_gp = cn; n_gq = cd; n_redok = 1'b0;
            end
            DC_DIVS, DC_QN, DC_QD: begin
                if (i_ctl.cmd == DC_DIVS) begin dvd = r_gp; dvs = r_gq; end
                else if (i_ctl.cmd == DC_QN) begin dvd = cn; dvs = r_gp; end
                else begin dvd = cd; dvs = r_gp; end
                n_dq = dvd[W-1] ? W'(-dvd) : W'(dvd);
                n_dv = dvs[W-1] ? W'(-dvs) : W'(dvs);
                n_dr = '0;
                n_dc = CW'(W);
                n_dnq = dvd[W-1] ^ dvs[W-1];
                n_dnr = dvd[W-1];
                n_dm1 = (dvs == -W'(1));
                if (i_ctl.cmd == DC_QD) n_qn = quo;
            end
            DC_DIVI: begin
                if (r_dc != '0) begin
                    n_dc = r_dc - CW'(1);
                    if (!trial[W]) begin
                        n_dr = trial[W-1:0];
                        n_dq = {r_dq[W-2:0], 1'b1};
                    end else begin
                        n_dr = {r_dr[W-2:0], r_dq[W-1]};
                        n_dq = {r_dq[W-2:0], 1'b0};
                    end
                end
            end
            DC_GSTEP: begin
                n_gp = r_gq; n_gq = rem;
            end
            DC_APPLY: begin
                // r_qn holds n/g, quo holds d/g; -1 by most negative is division by -1
                if (qm1) begin fn = cn; fd = cd; end
                else begin
                    fn = (r_gp == -W'(1)) ? -cn : r_qn;
                    fd = (r_gp == -W'(1)) ? -cd : quo;
                end
                if (fd[W-1] && fn != WMIN && fd != WMIN) begin
                    fn = -fn; fd = -fd;
                end
                if (i_ctl.sel_b) begin n_bn = fn; n_bd = fd; end
                else begin n_an = fn; n_ad = fd; end
                n_redok = (r_gp != W'(1)) && (r_gp != -W'(1));
            end
            DC_NEGF: begin
                if (cn == WMIN) fd = -cd;
                else fn = -cn;
                if (i_ctl.sel_b) begin n_bn = fn; n_bd = fd; end
                else begin n_an = fn; n_ad = fd; end
                n_rn = fn; n_rd = fd;
            end
            DC_FIN: begin
                n_rn = r_an; n_rd = r_ad;
            end
            default: ;
        endcase
    end

    assign o_sts.div_done = (r_dc == '0);
    assign o_sts.q_zero = (r_gq == '0);
    assign o_sts.fits = fits;
    assign o_sts.red_ok = r_redok;
    assign o_sts.g_zero = (r_gp == '0);
    assign o_sts.neg_min = (cn == WMIN);

    assign o_res_num = 32'(r_rn);
    assign o_res_den = 32'(r_rd);
    assign o_order = r_ord;
    assign o_status = r_ovf;

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: controller plus datapath over valid/ready words.
// The result is offered after the load, three product steps and the range check for
// add/sub/mul/div without overflow, and straight after the load for compare, smaller,
// larger, plain negate and spare codes. Each gcd remainder step runs a full division;
// each reduction adds two quotient divisions. Up to eight reductions per word, nine for sub.
// One word in flight; next accepted the cycle after the result is taken. Sync reset to idle.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_if.sink   i_in,
    rau_if.source o_out
);
    t_ctl        ctl;
    t_sts        sts;
    logic [31:0] rn, rd;
    logic [1:0]  ord;
    logic        st;
    logic [2:0]  tries;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.data[131:128]),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_tries     (tries)
    );

    rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_mode    (i_in.data[131:128]),
        .i_a_num   (i_in.data[127:96]),
        .i_a_den   (i_in.data[95:64]),
        .i_b_num   (i_in.data[63:32]),
        .i_b_den   (i_in.data[31:0]),
        .i_tries   (tries),
        .o_sts     (sts),
        .o_res_num (rn),
        .o_res_den (rd),
        .o_order   (ord),
        .o_status  (st)
    );

    assign o_out.data = {rn, rd, ord, st};
endmodule
